@@ rtl/tfn_pkg.sv @@
`default_nettype none

package tfn_pkg;

  localparam int CW    = 16;            // vertex coordinate width, Q8.8
  localparam int FB    = 14;            // normal fraction bits
  localparam int OW    = 16;            // normal component width
  localparam int SB    = 31;            // bit length of the scaled largest component

  localparam int EW    = CW + 1;        // edge width
  localparam int PW    = 2 * EW;        // product width
  localparam int XW    = PW + 1;        // cross component width, signed
  localparam int MAGW  = PW;            // cross magnitude width
  localparam int BLW   = $clog2(MAGW + 1);
  localparam int SQW   = 2 * SB + 2;    // sum of squares width
  localparam int RTW   = SB + 1;        // root width
  localparam int NUMW  = SB + FB + 1;   // dividend width
  localparam int QW    = FB + 1;        // quotient width
  localparam int SQ_STAGES = (RTW + 1) / 2;
  localparam int TW    = 32;

  typedef struct packed {
    logic signed [CW-1:0] vertex_a_x;
    logic signed [CW-1:0] vertex_a_y;
    logic signed [CW-1:0] vertex_a_z;
    logic signed [CW-1:0] vertex_b_x;
    logic signed [CW-1:0] vertex_b_y;
    logic signed [CW-1:0] vertex_b_z;
    logic signed [CW-1:0] vertex_c_x;
    logic signed [CW-1:0] vertex_c_y;
    logic signed [CW-1:0] vertex_c_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
    logic                 degenerate;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/triangle_face_normal.sv @@
// Unit face normal of one triangle per item, fully pipelined.
// Throughput: one item per cycle; busy is always low. The depth is set by
// the square root (two root bits per stage) and the divider (one bit per stage).
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// The receiver cannot stall: each result is presented for exactly one cycle.
`default_nettype none

module triangle_face_normal import tfn_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  typedef struct packed {
    logic [SQW-1:0] x;
    logic [SQW-1:0] r;
  } sq_t;

  function automatic sq_t sq_iter(sq_t a, int k);
    sq_t o;
    logic [SQW-1:0] b;
    logic [SQW-1:0] t;
    b = SQW'(1) << (2 * k);
    t = a.r + b;
    o = a;
    if (a.x >= t) begin
      o.x = a.x - t;
      o.r = (a.r >> 1) + b;
    end else begin
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  function automatic logic [MAGW-1:0] abs_x(logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = v[XW-1] ? -v : v;
    return t[MAGW-1:0];
  endfunction

  logic in_go;
  assign busy  = 1'b0;
  assign in_go = start & ~busy;

  // stage 1: edges
  logic                 s1_v_r;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  // stage 2: products
  logic                 s2_v_r;
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  // stage 3: cross magnitudes
  logic                 s3_v_r;
  logic [MAGW-1:0]      mag3_r [3];
  logic [2:0]           neg3_r;
  // stage 4: bit length
  logic                 s4_v_r;
  logic [MAGW-1:0]      mag4_r [3];
  logic [2:0]           neg4_r;
  logic [BLW-1:0]       bl_r;
  // stage 5: scaled magnitudes
  logic                 s5_v_r;
  logic [SB-1:0]        m5_r [3];
  logic [2:0]           neg5_r;
  logic                 deg5_r;
  // stage 6: squares
  logic                 s6_v_r;
  logic [SB-1:0]        m6_r [3];
  logic [2:0]           neg6_r;
  logic                 deg6_r;
  logic [2*SB-1:0]      sqr6_r [3];
  // square root pipeline
  logic                 sq_v_r   [SQ_STAGES+1];
  sq_t                  sq_r     [SQ_STAGES+1];
  logic [SB-1:0]        sq_m_r   [SQ_STAGES+1][3];
  logic [2:0]           sq_neg_r [SQ_STAGES+1];
  logic                 sq_deg_r [SQ_STAGES+1];
  // divider pipeline
  logic                 dv_v_r   [QW+1];
  logic [NUMW-1:0]      dv_rem_r [QW+1][3];
  logic [QW-1:0]        dv_q_r   [QW+1][3];
  logic [RTW-1:0]       dv_len_r [QW+1];
  logic [2:0]           dv_neg_r [QW+1];
  logic                 dv_deg_r [QW+1];
  // output
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic signed [XW-1:0] cx_nxt [3];
  logic [MAGW-1:0]      or_nxt;
  logic [BLW-1:0]       bl_nxt;
  logic [SB-1:0]        m_nxt [3];
  logic [RTW-1:0]       len_nxt;
  logic signed [OW-1:0] nrm_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cx_nxt[i] = XW'(pa_r[i]) - XW'(pb_r[i]);
    end
    or_nxt = mag3_r[0] | mag3_r[1] | mag3_r[2];
    bl_nxt = '0;
    for (int i = 0; i < MAGW; i++) begin
      if (or_nxt[i]) bl_nxt = BLW'(i + 1);
    end
  end

  always_comb begin
    logic [MAGW+SB-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t = (MAGW+SB)'(mag4_r[i]);
      if (bl_r > BLW'(SB)) t = t >> (bl_r - BLW'(SB));
      else                 t = t << (BLW'(SB) - bl_r);
      m_nxt[i] = t[SB-1:0];
    end
    len_nxt = sq_r[SQ_STAGES].r[RTW-1:0];
  end

  always_comb begin
    logic [TW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = TW'(dv_q_r[QW][i]);
      if (q > (TW'(1) << FB)) q = TW'(1) << FB;
      if (dv_neg_r[QW][i]) q = -q;
      nrm_nxt[i] = dv_deg_r[QW] ? '0 : q[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      for (int s = 0; s <= SQ_STAGES; s++) sq_v_r[s] <= 1'b0;
      for (int s = 0; s <= QW; s++) dv_v_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= in_go;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      sq_v_r[0] <= s6_v_r;
      for (int s = 0; s < SQ_STAGES; s++) sq_v_r[s+1] <= sq_v_r[s];
      dv_v_r[0] <= sq_v_r[SQ_STAGES];
      for (int s = 0; s < QW; s++) dv_v_r[s+1] <= dv_v_r[s];
      out_valid_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    // edges C-B and A-B
    e1_r[0] <= EW'(in_item.vertex_c_x) - EW'(in_item.vertex_b_x);
    e1_r[1] <= EW'(in_item.vertex_c_y) - EW'(in_item.vertex_b_y);
    e1_r[2] <= EW'(in_item.vertex_c_z) - EW'(in_item.vertex_b_z);
    e2_r[0] <= EW'(in_item.vertex_a_x) - EW'(in_item.vertex_b_x);
    e2_r[1] <= EW'(in_item.vertex_a_y) - EW'(in_item.vertex_b_y);
    e2_r[2] <= EW'(in_item.vertex_a_z) - EW'(in_item.vertex_b_z);

    pa_r[0] <= e1_r[1] * e2_r[2];
    pb_r[0] <= e1_r[2] * e2_r[1];
    pa_r[1] <= e1_r[2] * e2_r[0];
    pb_r[1] <= e1_r[0] * e2_r[2];
    pa_r[2] <= e1_r[0] * e2_r[1];
    pb_r[2] <= e1_r[1] * e2_r[0];

    for (int i = 0; i < 3; i++) begin
      mag3_r[i] <= abs_x(cx_nxt[i]);
      neg3_r[i] <= cx_nxt[i][XW-1];
    end

    mag4_r <= mag3_r;
    neg4_r <= neg3_r;
    bl_r   <= bl_nxt;

    m5_r   <= m_nxt;
    neg5_r <= neg4_r;
    deg5_r <= (bl_r == '0);

    m6_r   <= m5_r;
    neg6_r <= neg5_r;
    deg6_r <= deg5_r;
    for (int i = 0; i < 3; i++) sqr6_r[i] <= m5_r[i] * m5_r[i];

    sq_r[0].x   <= SQW'(sqr6_r[0]) + SQW'(sqr6_r[1]) + SQW'(sqr6_r[2]);
    sq_r[0].r   <= '0;
    sq_m_r[0]   <= m6_r;
    sq_neg_r[0] <= neg6_r;
    sq_deg_r[0] <= deg6_r;
    for (int s = 0; s < SQ_STAGES; s++) begin
      sq_r[s+1]     <= sq_iter(sq_iter(sq_r[s], RTW - 1 - 2 * s), RTW - 2 - 2 * s);
      sq_m_r[s+1]   <= sq_m_r[s];
      sq_neg_r[s+1] <= sq_neg_r[s];
      sq_deg_r[s+1] <= sq_deg_r[s];
    end

    // dividend m * 2^FB + floor(len/2)
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= (NUMW'(sq_m_r[SQ_STAGES][i]) << FB) + NUMW'(len_nxt >> 1);
      dv_q_r[0][i]   <= '0;
    end
    dv_len_r[0] <= len_nxt;
    dv_neg_r[0] <= sq_neg_r[SQ_STAGES];
    dv_deg_r[0] <= sq_deg_r[SQ_STAGES];
    for (int s = 0; s < QW; s++) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[s][i] >= (NUMW'(dv_len_r[s]) << (QW - 1 - s))) begin
          dv_rem_r[s+1][i] <= dv_rem_r[s][i] - (NUMW'(dv_len_r[s]) << (QW - 1 - s));
          dv_q_r[s+1][i]   <= {dv_q_r[s][i][QW-2:0], 1'b1};
        end else begin
          dv_rem_r[s+1][i] <= dv_rem_r[s][i];
          dv_q_r[s+1][i]   <= {dv_q_r[s][i][QW-2:0], 1'b0};
        end
      end
      dv_len_r[s+1] <= dv_len_r[s];
      dv_neg_r[s+1] <= dv_neg_r[s];
      dv_deg_r[s+1] <= dv_deg_r[s];
    end

    out_item_r.normal_x   <= nrm_nxt[0];
    out_item_r.normal_y   <= nrm_nxt[1];
    out_item_r.normal_z   <= nrm_nxt[2];
    out_item_r.degenerate <= dv_deg_r[QW];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
